[hdl/tcse_pkg.sv]
package tcse_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // character codes
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // register defaults and cell value after reset
  localparam logic [7:0]  ATTR_RESET = 8'h07;
  localparam logic [15:0] INIT_CELL  = {ATTR_RESET, CH_SPACE};

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISPLAY = 1'b0,
    REG_ATTR    = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_BACKSPACE = 2'd1,
    KIND_CLEAR     = 2'd2,
    KIND_READ      = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SWEEP,
    S_READ,
    S_EMIT
  } seq_state_t;

  // command beat
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } cmd_t;

  // result beat
  typedef struct packed {
    logic [7:0]  serial_byte;
    logic        serial_valid;
    logic [10:0] cursor_index;
    logic [15:0] read_cell;
    logic        last;
  } res_t;

endpackage

[hdl/tcse_ram.sv]
module tcse_ram
  #(parameter int WIDTH = 16,
    parameter int DEPTH = 2000)
  (input  logic                     clk,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/tcse_out_fifo.sv]
module tcse_out_fifo
  import tcse_pkg::*;
  (input  logic clk,
   input  logic rst,
   input  logic push,
   input  res_t push_data,
   output logic full,
   output logic res_valid,
   input  logic res_stall,
   output res_t res);

  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  res_t       entry [2];
  logic       pop;

  assign pop       = res_valid && !res_stall;
  assign full      = (count == 2'd2);
  assign res_valid = (count != 2'd0);
  assign res       = entry[rd_ptr];

  // two-entry queue between the sequencer and the result channel
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

[hdl/tcse_seq.sv]
module tcse_seq
  import tcse_pkg::*;
  #(parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF,
    localparam int CELLS  = COLUMNS * ROWS,
    localparam int AW     = $clog2(CELLS))
  (input  logic                  clk,
   input  logic                  rst,
   input  logic                  cmd_valid,
   output logic                  cmd_stall,
   input  cmd_t                  cmd,
   input  logic                  cfg_write,
   input  logic [CFG_IDX_W-1:0]  cfg_index,
   input  logic [CFG_DATA_W-1:0] cfg_data,
   output logic                  ram_we,
   output logic [AW-1:0]         ram_waddr,
   output logic [15:0]           ram_wdata,
   output logic                  ram_re,
   output logic [AW-1:0]         ram_raddr,
   input  logic [15:0]           ram_rdata,
   output logic                  push,
   output res_t                  push_data,
   input  logic                  full);

  localparam int CW       = $clog2(COLUMNS);
  localparam int RW       = $clog2(ROWS);
  localparam int LIN_W    = (AW > 11) ? AW : 11;
  localparam int COPY_END = CELLS - COLUMNS;

  seq_state_t       state, state_next;
  logic [AW-1:0]    ptr, ptr_next;
  logic [RW-1:0]    row, row_next;
  logic [CW-1:0]    col, col_next;
  logic             copy_mode, copy_mode_next;
  logic [15:0]      fill_word, fill_word_next;
  logic [3:0][7:0]  res_bytes, res_bytes_next;
  logic [1:0]       res_n, res_n_next;
  logic [1:0]       res_k, res_k_next;
  logic             res_echo, res_echo_next;
  logic [15:0]      res_cell, res_cell_next;
  logic             display_enabled;
  logic [7:0]       cell_attribute;

  logic [LIN_W-1:0] lin;
  logic [LIN_W-1:0] idx_wide;
  logic [31:0]      copy_src;
  logic             accept;
  logic             wrap;
  logic             res_last;

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;

  // linear cursor position
  assign lin      = LIN_W'(row) * LIN_W'(COLUMNS) + LIN_W'(col);
  assign idx_wide = LIN_W'(cmd.cell_index);
  assign copy_src = 32'(ptr) + 32'(COLUMNS) + 32'd1;
  assign res_last = (res_k == res_n);

  // result beat built from the held echo bytes and the final cursor
  always_comb begin
    push_data.serial_byte  = res_echo ? res_bytes[res_k] : 8'd0;
    push_data.serial_valid = res_echo;
    push_data.cursor_index = lin[10:0];
    push_data.read_cell    = res_cell;
    push_data.last         = res_last;
  end

  // next state, cursor moves and memory access
  always_comb begin
    state_next     = state;
    ptr_next       = ptr;
    row_next       = row;
    col_next       = col;
    copy_mode_next = copy_mode;
    fill_word_next = fill_word;
    res_bytes_next = res_bytes;
    res_n_next     = res_n;
    res_k_next     = res_k;
    res_echo_next  = res_echo;
    res_cell_next  = res_cell;
    ram_we         = 1'b0;
    ram_waddr      = lin[AW-1:0];
    ram_wdata      = {cell_attribute, cmd.char_code};
    ram_re         = 1'b0;
    ram_raddr      = idx_wide[AW-1:0];
    push           = 1'b0;
    wrap           = 1'b0;
    case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr;
        ram_wdata = INIT_CELL;
        ptr_next  = ptr + AW'(1);
        if (ptr == AW'(CELLS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next     = S_EMIT;
          res_k_next     = 2'd0;
          res_n_next     = 2'd0;
          res_echo_next  = 1'b1;
          res_cell_next  = 16'd0;
          res_bytes_next = '0;
          case (cmd.kind)
            KIND_CHAR: begin
              if (cmd.char_code == CH_CR) begin
                col_next          = '0;
                res_bytes_next[0] = CH_CR;
              end else if (cmd.char_code == CH_LF) begin
                col_next          = '0;
                wrap              = 1'b1;
                res_bytes_next[0] = CH_CR;
                res_bytes_next[1] = CH_LF;
                res_n_next        = 2'd1;
              end else begin
                ram_we            = display_enabled;
                res_bytes_next[0] = cmd.char_code;
                if (col == CW'(COLUMNS - 1)) begin
                  col_next = '0;
                  wrap     = 1'b1;
                end else begin
                  col_next = col + CW'(1);
                end
              end
              // row advance, scroll at the bottom while the display is on
              if (wrap) begin
                if (row == RW'(ROWS - 1)) begin
                  if (display_enabled) begin
                    state_next     = S_SWEEP;
                    copy_mode_next = 1'b1;
                    fill_word_next = {cell_attribute, CH_SPACE};
                    ptr_next       = '0;
                    ram_re         = 1'b1;
                    ram_raddr      = AW'(COLUMNS);
                  end
                end else begin
                  row_next = row + RW'(1);
                end
              end
            end
            KIND_BACKSPACE: begin
              if (row == '0 && col == '0) begin
                res_echo_next = 1'b0;
              end else begin
                if (col == '0) begin
                  row_next = row - RW'(1);
                  col_next = CW'(COLUMNS - 1);
                end else begin
                  col_next = col - CW'(1);
                end
                // previous cell is always one linear step back
                ram_we            = display_enabled;
                ram_waddr         = lin[AW-1:0] - AW'(1);
                ram_wdata         = {cell_attribute, CH_SPACE};
                res_bytes_next[0] = CH_BS;
                res_bytes_next[1] = CH_SPACE;
                res_bytes_next[2] = CH_BS;
                res_n_next        = 2'd2;
              end
            end
            KIND_CLEAR: begin
              res_echo_next = 1'b0;
              row_next      = '0;
              col_next      = '0;
              if (display_enabled) begin
                state_next     = S_SWEEP;
                copy_mode_next = 1'b0;
                fill_word_next = {cell_attribute, CH_SPACE};
                ptr_next       = '0;
              end
            end
            default: begin
              res_echo_next = 1'b0;
              if (32'(cmd.cell_index) < 32'(CELLS)) begin
                ram_re     = 1'b1;
                state_next = S_READ;
              end
            end
          endcase
        end
      end
      S_SWEEP: begin
        // scroll copies each row up from the one below and fills the last; clear fills all; read runs one ahead
        ram_we    = 1'b1;
        ram_waddr = ptr;
        ram_wdata = (copy_mode && (32'(ptr) < 32'(COPY_END))) ? ram_rdata : fill_word;
        ram_re    = copy_mode && (copy_src < 32'(CELLS));
        ram_raddr = copy_src[AW-1:0];
        ptr_next  = ptr + AW'(1);
        if (ptr == AW'(CELLS - 1)) begin
          state_next = S_EMIT;
        end
      end
      S_READ: begin
        res_cell_next = ram_rdata;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        if (!full) begin
          push       = 1'b1;
          res_k_next = res_k + 2'd1;
          if (res_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      ptr   <= '0;
      row   <= '0;
      col   <= '0;
      res_k <= 2'd0;
      res_n <= 2'd0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      row   <= row_next;
      col   <= col_next;
      res_k <= res_k_next;
      res_n <= res_n_next;
    end
  end

  // held result payload and sweep fill word
  always_ff @(posedge clk) begin
    copy_mode <= copy_mode_next;
    fill_word <= fill_word_next;
    res_bytes <= res_bytes_next;
    res_echo  <= res_echo_next;
    res_cell  <= res_cell_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      display_enabled <= 1'b1;
      cell_attribute  <= ATTR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DISPLAY: display_enabled <= cfg_data[0];
        REG_ATTR:    cell_attribute  <= cfg_data;
        default:     display_enabled <= display_enabled;
      endcase
    end
  end

endmodule

[hdl/text_console_scroll_engine.sv]
// one command at a time: the command is taken, then its result beats (1 to 3) go out
// one per cycle while the result queue is not full
// scroll and clear sweep the cell memory one entry per cycle while the display is on
// first result beat goes via the EMIT state (a read via READ first) and the result queue
// reset: cursor at 0, display on, attribute 7; a fill pass then writes every cell to a
// blank while cmd_stall stays high
module text_console_scroll_engine
  import tcse_pkg::*;
  #(parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF)
  (input  logic                  clk,
   input  logic                  rst,
   input  logic                  cmd_valid,
   output logic                  cmd_stall,
   input  cmd_t                  cmd,
   output logic                  res_valid,
   input  logic                  res_stall,
   output res_t                  res,
   input  logic                  cfg_write,
   input  logic [CFG_IDX_W-1:0]  cfg_index,
   input  logic [CFG_DATA_W-1:0] cfg_data);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;
  logic          push;
  res_t          push_data;
  logic          full;

  // command sequencer, cursor and configuration
  tcse_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // screen cell memory
  tcse_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result queue
  tcse_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

[hdl/tcse_check.sv]
module tcse_check
  import tcse_pkg::*;
  (input logic clk,
   input logic rst,
   input logic cmd_valid,
   input logic cmd_stall,
   input logic res_valid,
   input logic res_stall,
   input res_t res);

  // stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  // one command at a time
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command taken while previous one in progress");

  // fill pass blocks commands right after reset
  assert property (@(posedge clk)
    rst |=> cmd_stall)
    else $error("command port open during fill pass");

  // silent beats carry a zero byte
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.serial_valid || res.serial_byte == 8'd0))
    else $error("byte on a beat without echo");

  // cell data only on the single beat of a read
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.read_cell != 16'd0 |-> res.last && !res.serial_valid)
    else $error("cell data on an echo beat");

endmodule

bind text_console_scroll_engine tcse_check u_check (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

[sim/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcse_pkg::*;

  localparam int COLS     = COLUMNS_DEF;
  localparam int LINES    = ROWS_DEF;
  localparam int CELLS    = COLS * LINES;
  localparam int WATCHDOG = 20000;
  localparam int HOLD_LEN = 400;
  localparam res_t NO_BEAT = '0;

  typedef struct packed {
    cmd_t c;
    logic typed;
    res_t beat;
  } dir_row_t;

  typedef struct {
    bit         disp;
    logic [7:0] attr;
    int         send_pct;
    int         recv_pct;
    int         items;
    bit         hold;
  } phase_t;

  logic clk;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DISPLAY;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the console: cell words, cursor and registers
  logic [15:0] screen_mem [CELLS];
  int          cur_row = 0;
  int          cur_col = 0;
  bit          disp_on = 1'b1;
  logic [7:0]  attr_byte = ATTR_RESET;

  res_t step_beats[$];
  res_t pending_beats[$];
  res_t want_beat;
  int   errors = 0;
  int   idle_cycles = 0;
  int unsigned send_pct = 0;
  int unsigned recv_pct = 0;
  bit   hold_req = 1'b0;

  text_console_scroll_engine dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    int i;
    for (i = 0; i < CELLS; i++) screen_mem[i] = INIT_CELL;
  end

  // cell write, dropped while the display is off
  function automatic void store_cell(int row, int col, logic [7:0] ch);
    if (disp_on) screen_mem[row * COLS + col] = {attr_byte, ch};
  endfunction

  // move down one row, scrolling the screen up past the bottom while the display is on
  function automatic void next_row();
    int i;
    cur_row++;
    if (cur_row < LINES) return;
    if (disp_on) begin
      for (i = 0; i + COLS < CELLS; i++) screen_mem[i] = screen_mem[i + COLS];
      for (i = CELLS - COLS; i < CELLS; i++) screen_mem[i] = {attr_byte, CH_SPACE};
    end
    cur_row = LINES - 1;
  endfunction

  // apply one command to the shadow and build its result beats
  task automatic predict_console(input cmd_t c);
    logic [7:0]  echo [3];
    int          n;
    int          k;
    int          i;
    bit          has_echo;
    logic [15:0] cell_word;
    res_t        r;
    n = 1;
    has_echo = 1'b1;
    cell_word = '0;
    step_beats.delete();
    case (kind_t'(c.kind))
      KIND_CHAR: begin
        if (c.char_code == CH_CR) begin
          cur_col = 0;
          echo[0] = CH_CR;
        end else if (c.char_code == CH_LF) begin
          cur_col = 0;
          next_row();
          echo[0] = CH_CR;
          echo[1] = CH_LF;
          n = 2;
        end else begin
          store_cell(cur_row, cur_col, c.char_code);
          echo[0] = c.char_code;
          cur_col++;
          if (cur_col >= COLS) begin
            cur_col = 0;
            next_row();
          end
        end
      end
      KIND_BACKSPACE: begin
        if (cur_col == 0 && cur_row == 0) begin
          has_echo = 1'b0;
        end else begin
          if (cur_col == 0) begin
            cur_row--;
            cur_col = COLS - 1;
          end else begin
            cur_col--;
          end
          store_cell(cur_row, cur_col, CH_SPACE);
          echo[0] = CH_BS;
          echo[1] = CH_SPACE;
          echo[2] = CH_BS;
          n = 3;
        end
      end
      KIND_CLEAR: begin
        if (disp_on)
          for (i = 0; i < CELLS; i++) screen_mem[i] = {attr_byte, CH_SPACE};
        cur_row = 0;
        cur_col = 0;
        has_echo = 1'b0;
      end
      default: begin
        has_echo = 1'b0;
        if (c.cell_index < CELLS) cell_word = screen_mem[c.cell_index];
      end
    endcase
    for (k = 0; k < n; k++) begin
      r.serial_byte  = has_echo ? echo[k] : 8'd0;
      r.serial_valid = has_echo;
      r.cursor_index = 11'(cur_row * COLS + cur_col);
      r.read_cell    = cell_word;
      r.last         = (k == n - 1);
      step_beats.push_back(r);
    end
  endtask

  // offer one command beat, then log what it should produce
  task automatic send_cmd(input cmd_t c, input bit typed, input res_t typed_beat);
    int k;
    @(negedge clk);
    while ($urandom_range(99) < send_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    predict_console(c);
    if (typed) pending_beats.push_back(typed_beat);
    else for (k = 0; k < step_beats.size(); k++) pending_beats.push_back(step_beats[k]);
  endtask

  // drop valid and wait for every outstanding beat
  task automatic settle();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_DISPLAY) disp_on = val[0];
    else attr_byte = val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // result side: random stall, or a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  // compare each result beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected: byte %0h cursor %0d cell %0h",
               res.serial_byte, res.cursor_index, res.read_cell);
        errors++;
      end else begin
        want_beat = pending_beats.pop_front();
        if (res.serial_byte !== want_beat.serial_byte) begin
          $error("serial_byte: expected %0h, got %0h", want_beat.serial_byte, res.serial_byte);
          errors++;
        end
        if (res.serial_valid !== want_beat.serial_valid) begin
          $error("serial_valid: expected %0b, got %0b", want_beat.serial_valid,
                 res.serial_valid);
          errors++;
        end
        if (res.cursor_index !== want_beat.cursor_index) begin
          $error("cursor_index: expected %0d, got %0d", want_beat.cursor_index,
                 res.cursor_index);
          errors++;
        end
        if (res.read_cell !== want_beat.read_cell) begin
          $error("read_cell: expected %0h, got %0h", want_beat.read_cell, res.read_cell);
          errors++;
        end
        if (res.last !== want_beat.last) begin
          $error("last: expected %0b, got %0b", want_beat.last, res.last);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    dir_row_t   dir_tab [18];
    phase_t     phases [5];
    cmd_t       batch[$];
    int         p;
    int         i;
    int         len;
    int         term;
    int         pick;
    int         left;
    int         pos;
    logic [7:0] ch;
    logic [10:0] idx;

    dir_tab = '{
      // reset contents and out-of-range reads
      '{cmd_t'{KIND_READ, 8'd0, 11'd0},    1'b1, res_t'{8'd0, 1'b0, 11'd0, INIT_CELL, 1'b1}},
      '{cmd_t'{KIND_READ, 8'hFF, 11'd1999}, 1'b1, res_t'{8'd0, 1'b0, 11'd0, INIT_CELL, 1'b1}},
      '{cmd_t'{KIND_READ, 8'd0, 11'd2000}, 1'b1, res_t'{8'd0, 1'b0, 11'd0, 16'd0, 1'b1}},
      '{cmd_t'{KIND_READ, 8'd0, 11'h7FF},  1'b1, res_t'{8'd0, 1'b0, 11'd0, 16'd0, 1'b1}},
      // backspace at the origin does nothing
      '{cmd_t'{KIND_BACKSPACE, 8'd0, 11'd0}, 1'b1, res_t'{8'd0, 1'b0, 11'd0, 16'd0, 1'b1}},
      // byte extremes, backspace byte stored as text, return and line feed
      '{cmd_t'{KIND_CHAR, 8'h41, 11'd0},     1'b0, NO_BEAT},
      '{cmd_t'{KIND_CHAR, 8'hFF, 11'h7FF},   1'b0, NO_BEAT},
      '{cmd_t'{KIND_CHAR, 8'h00, 11'd0},     1'b0, NO_BEAT},
      '{cmd_t'{KIND_CHAR, CH_BS, 11'd0},     1'b0, NO_BEAT},
      '{cmd_t'{KIND_CHAR, CH_CR, 11'd0},     1'b0, NO_BEAT},
      '{cmd_t'{KIND_CHAR, CH_LF, 11'd0},     1'b0, NO_BEAT},
      // backspace from column zero, then a write that wraps at the right edge
      '{cmd_t'{KIND_BACKSPACE, 8'd0, 11'd0}, 1'b0, NO_BEAT},
      '{cmd_t'{KIND_CHAR, 8'h7E, 11'd0},     1'b0, NO_BEAT},
      '{cmd_t'{KIND_READ, 8'd0, 11'd79},     1'b0, NO_BEAT},
      '{cmd_t'{KIND_READ, 8'd0, 11'd3},      1'b0, NO_BEAT},
      '{cmd_t'{KIND_BACKSPACE, 8'd0, 11'd0}, 1'b0, NO_BEAT},
      // clear, then the first cell is blank again
      '{cmd_t'{KIND_CLEAR, 8'd0, 11'd0}, 1'b1, res_t'{8'd0, 1'b0, 11'd0, 16'd0, 1'b1}},
      '{cmd_t'{KIND_READ, 8'd0, 11'd0},  1'b1, res_t'{8'd0, 1'b0, 11'd0, INIT_CELL, 1'b1}}
    };

    phases = '{
      '{1'b1, 8'hFF, 0,  0,  60, 1'b0},
      '{1'b1, 8'h00, 63, 0,  50, 1'b0},
      '{1'b0, 8'h5A, 0,  63, 50, 1'b0},
      '{1'b1, 8'hA5, 11, 11, 50, 1'b1},
      '{1'b1, 8'h3C, 0,  0,  50, 1'b0}
    };

    // reset, the block then blanks its store on its own
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed beats
    for (i = 0; i < 18; i++) send_cmd(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].beat);

    // random phases, registers written only once the block is drained
    for (p = 0; p < 5; p++) begin
      settle();
      write_reg(REG_DISPLAY, {7'd0, phases[p].disp});
      write_reg(REG_ATTR, phases[p].attr);
      send_pct = phases[p].send_pct;
      recv_pct = phases[p].recv_pct;
      if (phases[p].hold) hold_req = 1'b1;
      left = phases[p].items;
      while (left > 0) begin
        batch.delete();
        pick = $urandom_range(99);
        if (pick < 45) begin
          // a line of text, mostly short, now and then past the right edge
          len = ($urandom_range(19) == 0) ? $urandom_range(90, 70) : $urandom_range(5);
          repeat (len) begin
            ch = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                          : 8'($urandom_range(8'h7E, 8'h20));
            batch.push_back(cmd_t'{KIND_CHAR, ch, 11'($urandom_range(2047))});
          end
          term = $urandom_range(4);
          if (term <= 2) batch.push_back(cmd_t'{KIND_CHAR, CH_LF, 11'd0});
          else if (term == 3) batch.push_back(cmd_t'{KIND_CHAR, CH_CR, 11'd0});
        end else if (pick < 60) begin
          // run of blank lines to push the cursor toward the bottom
          repeat ($urandom_range(6, 1)) batch.push_back(cmd_t'{KIND_CHAR, CH_LF, 11'd0});
        end else if (pick < 72) begin
          repeat ($urandom_range(4, 1)) begin
            batch.push_back(cmd_t'{KIND_BACKSPACE, 8'($urandom_range(255)),
                                   11'($urandom_range(2047))});
          end
        end else if (pick < 85) begin
          // reads, mostly just behind the cursor
          repeat ($urandom_range(3, 1)) begin
            pos = cur_row * COLS + cur_col - int'($urandom_range(3));
            if (pos < 0) pos = 0;
            idx = ($urandom_range(2) == 0) ? 11'($urandom_range(2047)) : 11'(pos);
            batch.push_back(cmd_t'{KIND_READ, 8'($urandom_range(255)), idx});
          end
        end else if (pick < 88) begin
          batch.push_back(cmd_t'{KIND_CLEAR, 8'($urandom_range(255)),
                                 11'($urandom_range(2047))});
        end else begin
          // noise: any kind, any byte, any index
          repeat ($urandom_range(3, 1)) begin
            batch.push_back(cmd_t'{2'($urandom_range(3)), 8'($urandom_range(255)),
                                   11'($urandom_range(2047))});
          end
        end
        for (i = 0; i < batch.size(); i++) send_cmd(batch[i], 1'b0, NO_BEAT);
        left -= batch.size();
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

[files.f]
hdl/tcse_pkg.sv
hdl/tcse_ram.sv
hdl/tcse_out_fifo.sv
hdl/tcse_seq.sv
hdl/text_console_scroll_engine.sv
hdl/tcse_check.sv
sim/tb_top.sv
